/* hw/rtl/gwps_pkg.sv */
// gwps_pkg: shared widths, sizes, codes and types for the grid word path search block
// no dependencies; used by gwps_grid_ram, grid_word_path_search and the bench
package gwps_pkg;

	// grid geometry, both sides powers of two so a cell index is {row, col}
	localparam int ROW_W      = 3;
	localparam int COL_W      = 3;
	localparam int CELL_W     = ROW_W + COL_W;
	localparam int MAX_ROWS   = 1 << ROW_W;
	localparam int MAX_COLS   = 1 << COL_W;
	localparam int CELL_COUNT = MAX_ROWS * MAX_COLS;

	// word store and lengths
	localparam int WORD_W   = 4;
	localparam int MAX_WORD = 1 << WORD_W;
	localparam int LEN_W    = WORD_W + 1;

	// characters and configuration registers
	localparam int CHAR_W = 8;
	localparam int CNT_W  = 4;
	localparam int REG_W  = 1;

	// configuration register indexes
	localparam logic [REG_W-1:0] REG_ROW_COUNT = 1'b0;
	localparam logic [REG_W-1:0] REG_COL_COUNT = 1'b1;

	// request codes
	typedef enum logic [1:0] {
		REQ_GRID   = 2'd0,
		REQ_WORD   = 2'd1,
		REQ_SEARCH = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [CELL_W-1:0] cell_t;

	// write side of the grid memory
	typedef struct packed {
		logic  en;
		cell_t addr;
		char_t data;
	} grid_wr_t;

endpackage

/* hw/rtl/grid_word_path_search.sv */
// grid_word_path_search: loads a character grid and a word, then runs a
// depth-first backtracking walk with an explicit stack to trace the word
// depends on gwps_pkg and gwps_grid_ram
//
//  channel | signals                                  | direction
//  --------+------------------------------------------+----------
//  config  | cfg_we, cfg_index, cfg_data              | in
//  request | in_valid/in_ready, req_type .. word_length | in
//  result  | out_valid/out_ready, found               | out
//
// grid and word loads are taken while idle; a search holds the block busy
// while it scans start cells, probes neighbors through the grid memory read,
// pops the stack or skips directions, leaves each exhausted start cell and
// passes the done state; every start cell and neighbor read goes through
// the single registered grid memory read port
// reset puts row_count and col_count at 8 and clears the visited map;
// grid and word contents are undefined until written
// a finished result sits in the output register; a second search result
// waits in the done state until the first is taken
module grid_word_path_search (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [gwps_pkg::REG_W-1:0]    cfg_index,
	input  logic [gwps_pkg::CNT_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    req_type,
	input  logic [gwps_pkg::ROW_W-1:0]    cell_row,
	input  logic [gwps_pkg::COL_W-1:0]    cell_col,
	input  logic [gwps_pkg::CHAR_W-1:0]   board_char,
	input  logic [gwps_pkg::WORD_W-1:0]   word_index,
	input  logic [gwps_pkg::CHAR_W-1:0]   word_char,
	input  logic [gwps_pkg::LEN_W-1:0]    word_length,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          found
);

	// direction codes kept per stack level
	localparam logic [2:0] DIR_UP    = 3'd0;
	localparam logic [2:0] DIR_DOWN  = 3'd1;
	localparam logic [2:0] DIR_LEFT  = 3'd2;
	localparam logic [2:0] DIR_RIGHT = 3'd3;
	localparam logic [2:0] DIR_DONE  = 3'd4;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_SCAN_CMP,
		S_STEP,
		S_CHECK,
		S_DONE
	} state_t;

	state_t                            state_q;
	logic [gwps_pkg::CNT_W-1:0]        row_count_q;
	logic [gwps_pkg::CNT_W-1:0]        col_count_q;
	logic [gwps_pkg::LEN_W-1:0]        len_q;
	logic [gwps_pkg::LEN_W-1:0]        sp_q;
	logic [gwps_pkg::ROW_W-1:0]        scan_r_q;
	logic [gwps_pkg::COL_W-1:0]        scan_c_q;
	gwps_pkg::cell_t                   ncell_q;
	logic [gwps_pkg::CELL_COUNT-1:0]   visited_q;
	logic                              res_q;
	logic                              out_valid_q;
	logic                              found_q;

	gwps_pkg::char_t                   word_q     [gwps_pkg::MAX_WORD];
	gwps_pkg::cell_t                   cell_stk_q [gwps_pkg::MAX_WORD];
	logic [2:0]                        dir_stk_q  [gwps_pkg::MAX_WORD];

	logic                              in_acc;
	gwps_pkg::grid_wr_t                grid_wr;
	gwps_pkg::cell_t                   rd_addr;
	gwps_pkg::char_t                   rd_data;
	logic [gwps_pkg::CNT_W-1:0]        rows_eff;
	logic [gwps_pkg::CNT_W-1:0]        cols_eff;
	logic [gwps_pkg::LEN_W-1:0]        len_in;
	logic [gwps_pkg::WORD_W-1:0]       sp_idx;
	logic [gwps_pkg::WORD_W-1:0]       top_idx;
	gwps_pkg::cell_t                   top_cell;
	logic [2:0]                        top_dir;
	logic [gwps_pkg::ROW_W-1:0]        cr;
	logic [gwps_pkg::COL_W-1:0]        cc;
	logic [gwps_pkg::ROW_W-1:0]        nr;
	logic [gwps_pkg::COL_W-1:0]        nc;
	logic                              nb_ok;
	gwps_pkg::cell_t                   ncell;
	logic                              adv_last;
	logic [gwps_pkg::ROW_W-1:0]        adv_r;
	logic [gwps_pkg::COL_W-1:0]        adv_c;
	logic                              word_match;
	logic                              cell_we;
	logic [gwps_pkg::WORD_W-1:0]       cell_widx;
	gwps_pkg::cell_t                   cell_wval;
	logic                              dir_we;
	logic [gwps_pkg::WORD_W-1:0]       dir_widx;
	logic [2:0]                        dir_wval;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign found     = found_q;

	// grid memory
	assign grid_wr.en   = in_acc && (req_type == gwps_pkg::REQ_GRID);
	assign grid_wr.addr = {cell_row, cell_col};
	assign grid_wr.data = board_char;
	assign rd_addr      = (state_q == S_SCAN) ? {scan_r_q, scan_c_q} : ncell;

	gwps_grid_ram u_grid_ram (
		.clk   (clk),
		.wr    (grid_wr),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	// register and length clamping
	always_comb begin
		rows_eff = row_count_q;
		if (row_count_q == '0) begin
			rows_eff = gwps_pkg::CNT_W'(1);
		end else if (row_count_q > gwps_pkg::CNT_W'(gwps_pkg::MAX_ROWS)) begin
			rows_eff = gwps_pkg::CNT_W'(gwps_pkg::MAX_ROWS);
		end
		cols_eff = col_count_q;
		if (col_count_q == '0) begin
			cols_eff = gwps_pkg::CNT_W'(1);
		end else if (col_count_q > gwps_pkg::CNT_W'(gwps_pkg::MAX_COLS)) begin
			cols_eff = gwps_pkg::CNT_W'(gwps_pkg::MAX_COLS);
		end
		len_in = word_length;
		if (word_length == '0) begin
			len_in = gwps_pkg::LEN_W'(1);
		end else if (word_length > gwps_pkg::LEN_W'(gwps_pkg::MAX_WORD)) begin
			len_in = gwps_pkg::LEN_W'(gwps_pkg::MAX_WORD);
		end
	end

	// next start cell in row-major order
	always_comb begin
		adv_last = 1'b0;
		adv_r    = scan_r_q;
		adv_c    = scan_c_q + 1'b1;
		if (gwps_pkg::CNT_W'(scan_c_q) + gwps_pkg::CNT_W'(1) >= cols_eff) begin
			adv_c = '0;
			adv_r = scan_r_q + 1'b1;
			adv_last = (gwps_pkg::CNT_W'(scan_r_q) + gwps_pkg::CNT_W'(1) >= rows_eff);
		end
	end

	// top of stack and neighbor for the current direction
	always_comb begin
		sp_idx   = sp_q[gwps_pkg::WORD_W-1:0];
		top_idx  = sp_idx - 1'b1;
		top_cell = cell_stk_q[top_idx];
		top_dir  = dir_stk_q[top_idx];
		cr       = top_cell[gwps_pkg::CELL_W-1:gwps_pkg::COL_W];
		cc       = top_cell[gwps_pkg::COL_W-1:0];
		nr       = cr;
		nc       = cc;
		nb_ok    = 1'b0;
		unique case (top_dir)
			DIR_UP: begin
				nr    = cr - 1'b1;
				nb_ok = (cr != '0);
			end
			DIR_DOWN: begin
				nr    = cr + 1'b1;
				nb_ok = (gwps_pkg::CNT_W'(cr) + gwps_pkg::CNT_W'(1) < rows_eff);
			end
			DIR_LEFT: begin
				nc    = cc - 1'b1;
				nb_ok = (cc != '0);
			end
			DIR_RIGHT: begin
				nc    = cc + 1'b1;
				nb_ok = (gwps_pkg::CNT_W'(cc) + gwps_pkg::CNT_W'(1) < cols_eff);
			end
			default: begin
				nb_ok = 1'b0;
			end
		endcase
		ncell = {nr, nc};
	end

	assign word_match = (rd_data == word_q[(state_q == S_SCAN_CMP) ? '0 : sp_idx]);

	// stack write requests
	always_comb begin
		cell_we   = 1'b0;
		cell_widx = sp_idx;
		cell_wval = ncell_q;
		dir_we    = 1'b0;
		dir_widx  = sp_idx;
		dir_wval  = DIR_UP;
		unique case (state_q)
			S_SCAN_CMP: begin
				cell_we   = word_match && (len_q != gwps_pkg::LEN_W'(1));
				cell_widx = '0;
				cell_wval = {scan_r_q, scan_c_q};
				dir_we    = cell_we;
				dir_widx  = '0;
			end
			S_STEP: begin
				dir_we   = (sp_q != '0) && (top_dir < DIR_DONE);
				dir_widx = top_idx;
				dir_wval = top_dir + 3'd1;
			end
			S_CHECK: begin
				cell_we = word_match && (sp_q + gwps_pkg::LEN_W'(1) != len_q);
				dir_we  = cell_we;
			end
			default: begin
				cell_we = 1'b0;
			end
		endcase
	end

	// word store
	always_ff @(posedge clk) begin
		if (in_acc && (req_type == gwps_pkg::REQ_WORD)) begin
			word_q[word_index] <= word_char;
		end
	end

	// path stacks
	always_ff @(posedge clk) begin
		if (cell_we) begin
			cell_stk_q[cell_widx] <= cell_wval;
		end
		if (dir_we) begin
			dir_stk_q[dir_widx] <= dir_wval;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= gwps_pkg::CNT_W'(8);
			col_count_q <= gwps_pkg::CNT_W'(8);
		end else if (cfg_we) begin
			if (cfg_index == gwps_pkg::REG_ROW_COUNT) begin
				row_count_q <= cfg_data;
			end else begin
				col_count_q <= cfg_data;
			end
		end
	end

	// search sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			len_q       <= gwps_pkg::LEN_W'(1);
			sp_q        <= '0;
			scan_r_q    <= '0;
			scan_c_q    <= '0;
			ncell_q     <= '0;
			visited_q   <= '0;
			res_q       <= 1'b0;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
		end else begin
			// the done state handles the output register itself
			if (out_valid_q && out_ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc && (req_type == gwps_pkg::REQ_SEARCH)) begin
						len_q     <= len_in;
						sp_q      <= '0;
						scan_r_q  <= '0;
						scan_c_q  <= '0;
						visited_q <= '0;
						state_q   <= S_SCAN;
					end
				end
				S_SCAN: begin
					state_q <= S_SCAN_CMP;
				end
				S_SCAN_CMP: begin
					if (word_match && (len_q == gwps_pkg::LEN_W'(1))) begin
						res_q   <= 1'b1;
						state_q <= S_DONE;
					end else if (word_match) begin
						visited_q[{scan_r_q, scan_c_q}] <= 1'b1;
						sp_q    <= gwps_pkg::LEN_W'(1);
						state_q <= S_STEP;
					end else if (adv_last) begin
						res_q   <= 1'b0;
						state_q <= S_DONE;
					end else begin
						scan_r_q <= adv_r;
						scan_c_q <= adv_c;
						state_q  <= S_SCAN;
					end
				end
				S_STEP: begin
					if (sp_q == '0) begin
						// walk from this start cell exhausted
						if (adv_last) begin
							res_q   <= 1'b0;
							state_q <= S_DONE;
						end else begin
							scan_r_q <= adv_r;
							scan_c_q <= adv_c;
							state_q  <= S_SCAN;
						end
					end else if (top_dir >= DIR_DONE) begin
						visited_q[top_cell] <= 1'b0;
						sp_q <= sp_q - gwps_pkg::LEN_W'(1);
					end else if (nb_ok && !visited_q[ncell]) begin
						ncell_q <= ncell;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (word_match && (sp_q + gwps_pkg::LEN_W'(1) == len_q)) begin
						res_q   <= 1'b1;
						state_q <= S_DONE;
					end else if (word_match) begin
						visited_q[ncell_q] <= 1'b1;
						sp_q    <= sp_q + gwps_pkg::LEN_W'(1);
						state_q <= S_STEP;
					end else begin
						state_q <= S_STEP;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						found_q     <= res_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// stack depth never reaches past the word
	assert property (@(posedge clk) disable iff (!arst_n) sp_q <= len_q)
		else $error("stack pointer beyond word length");

	// the cell on top of the path stack is marked visited
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STEP) && (sp_q != '0) |-> visited_q[top_cell])
		else $error("path cell not marked visited");

	// a probed neighbor was free when chosen
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK) |-> !visited_q[ncell_q])
		else $error("probing a visited cell");

	// a result is only loaded from the done state
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result raised outside done state");

endmodule

/* hw/rtl/gwps_grid_ram.sv */
// gwps_grid_ram: character grid storage, one write and one registered read per cycle
// depends on gwps_pkg for sizes and the write struct
module gwps_grid_ram (
	input  logic               clk,
	input  gwps_pkg::grid_wr_t wr,
	input  gwps_pkg::cell_t    raddr,
	output gwps_pkg::char_t    rdata
);

	gwps_pkg::char_t mem_q [gwps_pkg::CELL_COUNT];
	gwps_pkg::char_t rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* bench/tb.sv */
// tb: self-checking bench for grid_word_path_search, grid loads, word loads and searches
// predicts each search result with its own recursive path walk over mirrored stores
// depends on gwps_pkg and the grid_word_path_search rtl
module tb;

	localparam int SETTLE_CYCLES = 4;
	localparam int PHASE_ITEMS   = 390;

	logic                                clk;
	logic                                arst_n;
	logic                                cfg_we;
	logic [gwps_pkg::REG_W-1:0]          cfg_index;
	logic [gwps_pkg::CNT_W-1:0]          cfg_data;
	logic                                in_valid;
	logic                                in_ready;
	logic [1:0]                          req_type;
	logic [gwps_pkg::ROW_W-1:0]          cell_row;
	logic [gwps_pkg::COL_W-1:0]          cell_col;
	logic [gwps_pkg::CHAR_W-1:0]         board_char;
	logic [gwps_pkg::WORD_W-1:0]         word_index;
	logic [gwps_pkg::CHAR_W-1:0]         word_char;
	logic [gwps_pkg::LEN_W-1:0]          word_length;
	logic                                out_valid;
	logic                                out_ready;
	logic                                found;

	// mirrored block state
	gwps_pkg::char_t            board_mirror [gwps_pkg::CELL_COUNT];
	gwps_pkg::char_t            word_mirror [gwps_pkg::MAX_WORD];
	bit                         on_path [gwps_pkg::CELL_COUNT];
	logic [gwps_pkg::CNT_W-1:0] rows_reg;
	logic [gwps_pkg::CNT_W-1:0] cols_reg;

	bit              pending_found [$];
	bit              oldest_found;
	int              mismatch_count;
	int              items_sent;
	int              send_idle_pct;
	int              stall_pct;
	gwps_pkg::char_t letters [4];

	grid_word_path_search DUT (.*);

	// clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	// hard stop
	initial begin
		#40000000;
		$display("== FAIL ==");
		$finish;
	end

	function automatic int clamp_count(int v, int hi);
		if (v == 0)
			return 1;
		if (v > hi)
			return hi;
		return v;
	endfunction

	// depth-first extension from a cell that already matches word position pos
	function automatic bit extend_path(int r, int c, int pos, int len, int rows, int cols);
		int d;
		int nr;
		int nc;
		bit hit;
		if (pos + 1 >= len)
			return 1'b1;
		on_path[r*gwps_pkg::MAX_COLS+c] = 1'b1;
		hit = 1'b0;
		for (d = 0; d < 4 && !hit; d++) begin
			nr = r;
			nc = c;
			case (d)
				0: nr = r - 1;
				1: nr = r + 1;
				2: nc = c - 1;
				default: nc = c + 1;
			endcase
			if (nr >= 0 && nr < rows && nc >= 0 && nc < cols &&
			    !on_path[nr*gwps_pkg::MAX_COLS+nc] &&
			    board_mirror[nr*gwps_pkg::MAX_COLS+nc] == word_mirror[pos+1])
				hit = extend_path(nr, nc, pos + 1, len, rows, cols);
		end
		on_path[r*gwps_pkg::MAX_COLS+c] = 1'b0;
		return hit;
	endfunction

	// expected found flag for a search of the given raw length
	function automatic bit word_traceable(logic [gwps_pkg::LEN_W-1:0] len_raw);
		int rows;
		int cols;
		int len;
		int r;
		int c;
		rows = clamp_count(rows_reg, gwps_pkg::MAX_ROWS);
		cols = clamp_count(cols_reg, gwps_pkg::MAX_COLS);
		len = clamp_count(len_raw, gwps_pkg::MAX_WORD);
		on_path = '{default: 1'b0};
		for (r = 0; r < rows; r++)
			for (c = 0; c < cols; c++)
				if (board_mirror[r*gwps_pkg::MAX_COLS+c] == word_mirror[0] &&
				    extend_path(r, c, 0, len, rows, cols))
					return 1'b1;
		return 1'b0;
	endfunction

	// receiver stalls and result check
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
		if (arst_n && out_valid && out_ready) begin
			if (pending_found.size() == 0) begin
				$error("found: expected none, actual %0b", found);
				mismatch_count++;
			end else begin
				oldest_found = pending_found.pop_front();
				if (found !== oldest_found) begin
					$error("found: expected %0b, actual %0b", oldest_found, found);
					mismatch_count++;
				end
			end
		end
	end

	// present one item, hold it until accepted, then update the mirrors
	task automatic send_item(gwps_pkg::req_t kind, logic [gwps_pkg::ROW_W-1:0] row,
	                         logic [gwps_pkg::COL_W-1:0] col, gwps_pkg::char_t bch,
	                         logic [gwps_pkg::WORD_W-1:0] widx, gwps_pkg::char_t wch,
	                         logic [gwps_pkg::LEN_W-1:0] len);
		// idle cycles drawn one at a time so the idle share matches the plan
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		req_type    <= kind;
		cell_row    <= row;
		cell_col    <= col;
		board_char  <= bch;
		word_index  <= widx;
		word_char   <= wch;
		word_length <= len;
		do @(posedge clk); while (!in_ready);
		items_sent++;
		case (kind)
			gwps_pkg::REQ_GRID:   board_mirror[{row, col}] = bch;
			gwps_pkg::REQ_WORD:   word_mirror[widx] = wch;
			gwps_pkg::REQ_SEARCH: pending_found.push_back(word_traceable(len));
			default: ;
		endcase
	endtask

	task automatic put_cell(int r, int c, gwps_pkg::char_t ch);
		send_item(gwps_pkg::REQ_GRID, gwps_pkg::ROW_W'(r), gwps_pkg::COL_W'(c), ch,
		          gwps_pkg::WORD_W'($urandom), gwps_pkg::char_t'($urandom),
		          gwps_pkg::LEN_W'($urandom));
	endtask

	task automatic put_word(int i, gwps_pkg::char_t ch);
		send_item(gwps_pkg::REQ_WORD, gwps_pkg::ROW_W'($urandom), gwps_pkg::COL_W'($urandom),
		          gwps_pkg::char_t'($urandom), gwps_pkg::WORD_W'(i), ch,
		          gwps_pkg::LEN_W'($urandom));
	endtask

	task automatic search(int len);
		send_item(gwps_pkg::REQ_SEARCH, gwps_pkg::ROW_W'($urandom), gwps_pkg::COL_W'($urandom),
		          gwps_pkg::char_t'($urandom), gwps_pkg::WORD_W'($urandom),
		          gwps_pkg::char_t'($urandom), gwps_pkg::LEN_W'(len));
	endtask

	// drop valid and wait until every search result is back
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_found.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write both geometry registers while the block is idle
	task automatic set_geometry(int rows_raw, int cols_raw);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= gwps_pkg::REG_ROW_COUNT;
		cfg_data  <= gwps_pkg::CNT_W'(rows_raw);
		@(posedge clk);
		cfg_index <= gwps_pkg::REG_COL_COUNT;
		cfg_data  <= gwps_pkg::CNT_W'(cols_raw);
		@(posedge clk);
		cfg_we   <= 1'b0;
		rows_reg = gwps_pkg::CNT_W'(rows_raw);
		cols_reg = gwps_pkg::CNT_W'(cols_raw);
	endtask

	function automatic gwps_pkg::char_t pick_letter();
		return letters[$urandom_range(3)];
	endfunction

	// lay the word along a random self-avoiding walk, stop laying cells when stuck
	task automatic plant_word(int len, int rows, int cols);
		int r;
		int c;
		int i;
		int d;
		int nr;
		int nc;
		int tries;
		bit moved;
		bit stuck;
		bit taken [gwps_pkg::CELL_COUNT];
		gwps_pkg::char_t ch;
		taken = '{default: 1'b0};
		r = $urandom_range(rows - 1);
		c = $urandom_range(cols - 1);
		stuck = 1'b0;
		for (i = 0; i < len; i++) begin
			ch = pick_letter();
			put_word(i, ch);
			if (i > 0 && !stuck) begin
				moved = 1'b0;
				for (tries = 0; tries < 8 && !moved; tries++) begin
					d = $urandom_range(3);
					nr = r;
					nc = c;
					case (d)
						0: nr--;
						1: nr++;
						2: nc--;
						default: nc++;
					endcase
					if (nr >= 0 && nr < rows && nc >= 0 && nc < cols &&
					    !taken[nr*gwps_pkg::MAX_COLS+nc]) begin
						r = nr;
						c = nc;
						moved = 1'b1;
					end
				end
				stuck = !moved;
			end
			if (!stuck) begin
				taken[r*gwps_pkg::MAX_COLS+c] = 1'b1;
				put_cell(r, c, ch);
			end
		end
	endtask

	// one random scenario: maybe new geometry, grid content, planted word, searches
	task automatic run_scenario();
		int rows;
		int cols;
		int len;
		int r;
		int c;
		gwps_pkg::char_t base;
		gwps_pkg::char_t step;
		if ($urandom_range(3) == 0)
			set_geometry($urandom_range(15), $urandom_range(15));
		else if ($urandom_range(7) == 0)
			wait_idle();
		rows = clamp_count(rows_reg, gwps_pkg::MAX_ROWS);
		cols = clamp_count(cols_reg, gwps_pkg::MAX_COLS);
		// four distinct letters keep the backtracking fan-out low
		base = gwps_pkg::char_t'($urandom);
		step = gwps_pkg::char_t'($urandom) | 8'h01;
		for (r = 0; r < 4; r++)
			letters[r] = base + gwps_pkg::char_t'(r) * step;
		if ($urandom_range(2) == 0) begin
			for (r = 0; r < rows; r++)
				for (c = 0; c < cols; c++)
					put_cell(r, c, pick_letter());
		end else begin
			repeat ($urandom_range(1, 8))
				put_cell($urandom_range(7), $urandom_range(7),
				         ($urandom_range(3) == 0) ? gwps_pkg::char_t'($urandom) :
				                                    pick_letter());
		end
		len = $urandom_range(1, gwps_pkg::MAX_WORD);
		plant_word(len, rows, cols);
		// sometimes break the planted word
		if ($urandom_range(3) == 0)
			put_word($urandom_range(len - 1), pick_letter());
		search(len);
		repeat ($urandom_range(2))
			search(($urandom_range(4) == 0) ? $urandom_range(31) : $urandom_range(1, len));
	endtask

	// single cell grid, length clamping at zero and one
	task automatic test_unit_grid();
		set_geometry(0, 0);
		put_cell(0, 0, 8'hFF);
		put_word(0, 8'hFF);
		search(0);
		search(1);
		put_word(1, 8'h00);
		search(2);
		wait_idle();
	endtask

	// reserved request code gives nothing and disturbs nothing
	task automatic test_unknown_request();
		send_item(gwps_pkg::REQ_NONE, 3'h7, 3'h7, 8'hFF, 4'hF, 8'hFF, 5'h1F);
		send_item(gwps_pkg::REQ_NONE, 3'h0, 3'h0, 8'h00, 4'h0, 8'h00, 5'h00);
		search(1);
		wait_idle();
	endtask

	// snake through a 2x3 grid, then a word that would need a cell twice
	task automatic test_snake_path();
		set_geometry(2, 3);
		put_cell(0, 0, 8'h00);
		put_cell(0, 1, 8'h5A);
		put_cell(0, 2, 8'hA5);
		put_cell(1, 2, 8'h3C);
		put_cell(1, 1, 8'hC3);
		put_cell(1, 0, 8'hFF);
		put_word(0, 8'h00);
		put_word(1, 8'h5A);
		put_word(2, 8'hA5);
		put_word(3, 8'h3C);
		put_word(4, 8'hC3);
		put_word(5, 8'hFF);
		search(6);
		put_word(2, 8'h00);
		search(3);
		search(2);
		wait_idle();
	endtask

	// uniform grid with a last letter that never matches: full backtracking
	task automatic test_exhaustive_backtrack();
		int k;
		for (k = 0; k < 6; k++)
			put_cell(k / 3, k % 3, 8'h81);
		for (k = 0; k < 5; k++)
			put_word(k, 8'h81);
		put_word(5, 8'h18);
		search(6);
		search(5);
		wait_idle();
	endtask

	// full store load, then random scenarios under four idling plans
	task automatic test_random_traffic();
		int k;
		int stop_at;
		set_geometry(15, 8);
		for (k = 0; k < gwps_pkg::CELL_COUNT; k++)
			put_cell(k / gwps_pkg::MAX_COLS, k % gwps_pkg::MAX_COLS,
			         gwps_pkg::char_t'($urandom));
		for (k = 0; k < gwps_pkg::MAX_WORD; k++)
			put_word(k, gwps_pkg::char_t'($urandom));
		for (k = 0; k < 4; k++) begin
			case (k)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 45; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 45; end
				default: begin send_idle_pct = 9; stall_pct = 9; end
			endcase
			stop_at = items_sent + PHASE_ITEMS;
			while (items_sent < stop_at)
				run_scenario();
		end
		set_geometry(8, 15);
		search($urandom_range(1, gwps_pkg::MAX_WORD));
		wait_idle();
	endtask

	// main sequence
	initial begin
		mismatch_count = 0;
		items_sent = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		rows_reg = gwps_pkg::CNT_W'(gwps_pkg::MAX_ROWS);
		cols_reg = gwps_pkg::CNT_W'(gwps_pkg::MAX_COLS);
		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_index   <= '0;
		cfg_data    <= '0;
		in_valid    <= 1'b0;
		req_type    <= gwps_pkg::REQ_GRID;
		cell_row    <= '0;
		cell_col    <= '0;
		board_char  <= '0;
		word_index  <= '0;
		word_char   <= '0;
		word_length <= '0;
		out_ready   <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_unit_grid();
		test_unknown_request();
		test_snake_path();
		test_exhaustive_backtrack();
		test_random_traffic();
		wait_idle();
		repeat (30) @(posedge clk);
		if (mismatch_count == 0 && pending_found.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
